// File: design/hpm_pkg.sv
`default_nettype none

package hpm_pkg;

  // Default values of the top-level parameters.
  localparam int PATTERN_MAX_DEF   = 32;
  localparam int ALPHABET_SIZE_DEF = 128;
  localparam int POSITION_BITS_DEF = 32;

  // Fixed widths of the interface fields.
  localparam int CHAR_W    = 7;
  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 6;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;
  localparam int MATCH_W   = 32;
  localparam int ALPHA_W   = 9;

  // Pattern storage: four configuration words of eight bytes each.
  localparam int PAT_STORE = 32;
  localparam int PAT_W     = PAT_STORE * BYTE_W;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_3 = 3'd4;

  // Status that each cell of the window row reports to the top level.
  typedef struct packed {
    logic win_ok;    // window character agrees with its aligned pattern byte
    logic scan_hit;  // incoming character equals this cell's pattern byte
  } hpm_cell_sts_t;

  // A pattern byte outside the alphabet never equals a text character.
  function automatic logic char_eq(input logic [BYTE_W-1:0]  pat,
                                   input logic [CHAR_W-1:0]  chr,
                                   input logic [ALPHA_W-1:0] alpha);
    char_eq = ({1'b0, pat} < alpha) && (pat == {1'b0, chr});
  endfunction

endpackage

`default_nettype wire

// File: design/hpm_cell.sv
`default_nettype none

module hpm_cell #(
  parameter int ALPHABET_SIZE = hpm_pkg::ALPHABET_SIZE_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          shift_en,
  input  wire logic [hpm_pkg::CHAR_W-1:0]    char_in,
  output logic      [hpm_pkg::CHAR_W-1:0]    char_out,
  input  wire logic [hpm_pkg::BYTE_W-1:0]    align_pat,
  input  wire logic                          in_use,
  input  wire logic [hpm_pkg::BYTE_W-1:0]    scan_pat,
  input  wire logic [hpm_pkg::CHAR_W-1:0]    scan_char,
  input  wire logic                          scan_ok,
  output hpm_pkg::hpm_cell_sts_t             sts
);

  localparam logic [hpm_pkg::ALPHA_W-1:0] ALPHA = hpm_pkg::ALPHA_W'(ALPHABET_SIZE);

  logic [hpm_pkg::CHAR_W-1:0] win_r;
  logic [hpm_pkg::BYTE_W-1:0] ap_r;
  logic                       in_use_r;

  // One window character; it moves one cell along with every accepted item.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      win_r <= char_in;
    end
  end

  // The aligned pattern byte follows the configuration through a register.
  always_ff @(posedge clk) begin
    ap_r     <= align_pat;
    in_use_r <= in_use;
  end

  assign char_out     = win_r;
  assign sts.win_ok   = !in_use_r || hpm_pkg::char_eq(ap_r, win_r, ALPHA);
  assign sts.scan_hit = scan_ok && hpm_pkg::char_eq(scan_pat, scan_char, ALPHA);

endmodule

`default_nettype wire

// File: design/hpm_out_queue.sv
`default_nettype none

module hpm_out_queue (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        push,
  input  wire logic [hpm_pkg::MATCH_W-1:0] push_data,
  output logic [1:0]                       count,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [hpm_pkg::MATCH_W-1:0]      out_tdata
);

  logic [hpm_pkg::MATCH_W-1:0] q_r [2];
  logic                        wr_ptr_r;
  logic                        rd_ptr_r;
  logic [1:0]                  cnt_r;
  logic [1:0]                  cnt_nxt;
  logic                        pop;

  assign pop        = out_tvalid && out_tready;
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = q_r[rd_ptr_r];
  assign count      = cnt_r;

  // Occupancy follows pushes and pops.
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  // Two-entry result queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

  // A push into a full queue would lose a result.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r != 2'd2 || pop))
    else $error("result pushed into a full queue");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result queue count out of range");

endmodule

`default_nettype wire

// File: design/horspool_pattern_matcher.sv
// Streaming Horspool matcher.
// The input channel (in_*) carries one text character per item; in_tuser
// set marks the first character of a new text and restarts the offset count.
// The result channel (out_*) carries the start offset of each full match.
// The user must load the pattern and its length through cfg_* while no item
// is in flight; the block does not enforce this. Writes to indexes past the
// pattern words are dropped. Throughput is one item per cycle while in_tready
// is high. The bound is the alignment update: the incoming character is
// compared against every pattern byte but the last, the rightmost hit is
// encoded and the shift is added to the alignment end, all in the accept
// cycle. The window row registers the accepted character, then the window
// compare writes each match into a two-entry result queue that drives out_*.
// When the receiver stalls the queue holds the results; in_tready drops
// only when the queue and a pending compare could otherwise overflow.
// Reset clears the pattern, sets the length to one and zeroes the offset
// and alignment end; the window characters are not cleared.
`default_nettype none

module horspool_pattern_matcher #(
  parameter int PATTERN_MAX   = hpm_pkg::PATTERN_MAX_DEF,
  parameter int ALPHABET_SIZE = hpm_pkg::ALPHABET_SIZE_DEF,
  parameter int POSITION_BITS = hpm_pkg::POSITION_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [7:0]                    in_tdata,    // [6:0] text_char, [7] zero
  input  wire logic                          in_tuser,    // [0] text_start
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [hpm_pkg::MATCH_W-1:0]        out_tdata,   // [31:0] match_start
  input  wire logic                          cfg_wr_en,
  input  wire logic [hpm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [hpm_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int POS_W = POSITION_BITS;
  localparam int SUM_W = POSITION_BITS + 1;
  localparam int LEN_W = hpm_pkg::LEN_W;
  localparam int CAP   = (PATTERN_MAX < hpm_pkg::PAT_STORE) ? PATTERN_MAX
                                                            : hpm_pkg::PAT_STORE;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // Configuration registers.
  logic [LEN_W-1:0]          len_r;
  logic [hpm_pkg::PAT_W-1:0] pat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_W'(1);
      pat_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        hpm_pkg::REG_LENGTH: len_r          <= cfg_wdata[LEN_W-1:0];
        hpm_pkg::REG_WORD_0: pat_r[63:0]    <= cfg_wdata;
        hpm_pkg::REG_WORD_1: pat_r[127:64]  <= cfg_wdata;
        hpm_pkg::REG_WORD_2: pat_r[191:128] <= cfg_wdata;
        hpm_pkg::REG_WORD_3: pat_r[255:192] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Effective length, clamped to one and to the pattern capacity.
  logic [LEN_W-1:0] m;
  logic [LEN_W-1:0] m_less1;

  always_comb begin
    if (len_r == '0) begin
      m = LEN_W'(1);
    end else if (len_r > LEN_W'(CAP)) begin
      m = LEN_W'(CAP);
    end else begin
      m = len_r;
    end
  end

  assign m_less1 = m - LEN_W'(1);

  // Pattern aligned to the window: cell k sees pattern byte m-1-k.
  logic [hpm_pkg::PAT_W-1:0] pat_rev;
  logic [hpm_pkg::PAT_W-1:0] pat_al;
  logic [LEN_W-1:0]          al_amt;

  always_comb begin
    for (int k = 0; k < hpm_pkg::PAT_STORE; k++) begin
      pat_rev[k*hpm_pkg::BYTE_W +: hpm_pkg::BYTE_W] =
        pat_r[(hpm_pkg::PAT_STORE-1-k)*hpm_pkg::BYTE_W +: hpm_pkg::BYTE_W];
    end
  end

  assign al_amt = LEN_W'(hpm_pkg::PAT_STORE) - m;
  assign pat_al = pat_rev >> {al_amt, 3'b000};

  // Handshake and alignment control.
  logic                         in_acc;
  logic [hpm_pkg::CHAR_W-1:0]   in_char;
  logic [POS_W-1:0]             position_r;
  logic [POS_W-1:0]             next_check_r;
  logic [POS_W-1:0]             idx;
  logic [POS_W-1:0]             nc;
  logic                         hit;
  logic                         do_cmp;
  logic                         chk_r;
  logic [POS_W-1:0]             off_r;

  assign in_acc  = in_tvalid && in_tready;
  assign in_char = in_tdata[hpm_pkg::CHAR_W-1:0];
  assign idx     = in_tuser ? '0 : position_r;
  assign nc      = in_tuser ? POS_W'(m_less1) : next_check_r;
  assign hit     = (idx != POS_MAX) && (idx == nc);
  assign do_cmp  = hit && (idx >= POS_W'(m_less1));

  // Row of window cells.
  hpm_pkg::hpm_cell_sts_t     sts   [PATTERN_MAX];
  logic [hpm_pkg::CHAR_W-1:0] win_c [PATTERN_MAX];
  logic [PATTERN_MAX-1:0]     ok_vec;
  logic [PATTERN_MAX-1:0]     scan_vec;

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    logic [hpm_pkg::CHAR_W-1:0] c_in;
    logic [hpm_pkg::BYTE_W-1:0] c_al;
    logic [hpm_pkg::BYTE_W-1:0] c_sp;

    if (k == 0) begin : g_head
      assign c_in = in_char;
    end else begin : g_link
      assign c_in = win_c[k-1];
    end

    if (k < hpm_pkg::PAT_STORE) begin : g_pat
      assign c_al = pat_al[k*hpm_pkg::BYTE_W +: hpm_pkg::BYTE_W];
      assign c_sp = pat_r[k*hpm_pkg::BYTE_W +: hpm_pkg::BYTE_W];
    end else begin : g_nopat
      assign c_al = '0;
      assign c_sp = '0;
    end

    hpm_cell #(
      .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_cell (
      .clk       (clk),
      .shift_en  (in_acc),
      .char_in   (c_in),
      .char_out  (win_c[k]),
      .align_pat (c_al),
      .in_use    (LEN_W'(k) < m),
      .scan_pat  (c_sp),
      .scan_char (in_char),
      .scan_ok   (LEN_W'(k) < m_less1),
      .sts       (sts[k])
    );

    assign ok_vec[k]   = sts[k].win_ok;
    assign scan_vec[k] = sts[k].scan_hit;
  end

  // Bad-character shift from the rightmost pattern hit.
  logic             found;
  logic [LEN_W-1:0] jsel;
  logic [LEN_W-1:0] shift;

  always_comb begin
    found = 1'b0;
    jsel  = '0;
    for (int j = 0; j < PATTERN_MAX; j++) begin
      if (scan_vec[j]) begin
        found = 1'b1;
        jsel  = LEN_W'(j);
      end
    end
    shift = found ? (m_less1 - jsel) : m;
  end

  // Saturating updates of the offset count and the alignment end.
  logic [SUM_W-1:0] nc_sum;
  logic [POS_W-1:0] nc_add;
  logic [POS_W-1:0] pos_inc;

  assign nc_sum  = {1'b0, nc} + SUM_W'(shift);
  assign nc_add  = nc_sum[POS_W] ? POS_MAX : nc_sum[POS_W-1:0];
  assign pos_inc = (idx == POS_MAX) ? idx : idx + POS_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r   <= '0;
      next_check_r <= '0;
      chk_r        <= 1'b0;
    end else begin
      chk_r <= in_acc && do_cmp;
      if (in_acc) begin
        position_r   <= pos_inc;
        next_check_r <= hit ? nc_add : nc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      off_r <= idx - POS_W'(m_less1);
    end
  end

  // Window compare result goes to the result queue.
  logic       push;
  logic [1:0] q_cnt;
  logic [2:0] occ;
  logic       pop;

  assign push = chk_r && (&ok_vec);

  hpm_out_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (hpm_pkg::MATCH_W'(off_r)),
    .count      (q_cnt),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Accept only if the queue can take the pending and the new result.
  assign pop       = out_tvalid && out_tready;
  assign occ       = 3'(q_cnt) + 3'(chk_r);
  assign in_tready = pop ? (occ <= 3'd2) : (occ <= 3'd1);

  // A pending compare always comes from an item accepted the cycle before.
  a_chk_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    chk_r |-> $past(in_tvalid && in_tready))
    else $error("window compare without an accepted item");

  // Without a text start the offset count never moves backward.
  a_pos_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !in_tuser) |=> (position_r >= $past(position_r)))
    else $error("offset count moved backward");

endmodule

`default_nettype wire
